[rtl/oace_pkg.sv]
// ----------------------------------------------------------------------------
// oace_pkg
// Types and constants shared by the counter and alarm engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package oace_pkg;

    localparam int NUM_ALARMS = 8;
    localparam int TIME_W     = 16;
    localparam int IDX_W      = 3;
    localparam int DIV_W      = TIME_W + 1;
    localparam int DCNT_W     = $clog2(DIV_W);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [1:0] KIND_EXPIRY  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_START,
        S_CNT_WAIT,
        S_SCAN,
        S_ALM_WAIT,
        S_EMIT,
        S_SUM,
        S_ACK
    } t_state;

    typedef struct packed {
        logic load;
        logic div_cnt_start;
        logic cnt_update;
        logic div_alm_start;
        logic alm_pass;
        logic alm_shot;
        logic alm_div;
        logic emit_exp;
        logic emit_sum;
        logic emit_ack;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       out_free;
        logic       div_done;
        logic       alm_en;
        logic       alm_late;
        logic       alm_one;
        logic       idx_last;
    } t_status;

endpackage

`default_nettype wire

[rtl/oace_div.sv]
// ----------------------------------------------------------------------------
// oace_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oace_div
    import oace_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quo,
    output logic [DIV_W-1:0]      o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_bit;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_bit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_bit};
            r_rem <= w_bit ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[rtl/oace_ctrl.sv]
// ----------------------------------------------------------------------------
// oace_ctrl
// Sequencer: walks a tick through the counter update and the alarm table.
// ----------------------------------------------------------------------------
`default_nettype none

module oace_ctrl
    import oace_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_stat,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_stat.op)
                        OP_TICK:   n_state = S_CNT_START;
                        OP_ARM:    n_state = S_ACK;
                        OP_CANCEL: n_state = S_ACK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CNT_START: n_state = S_CNT_WAIT;
            S_CNT_WAIT: begin
                if (i_stat.div_done) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.alm_en && !i_stat.alm_late) begin
                    n_state = i_stat.alm_one ? S_EMIT : S_ALM_WAIT;
                end else if (i_stat.idx_last) begin
                    n_state = S_SUM;
                end
            end
            S_ALM_WAIT: begin
                if (i_stat.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.idx_last ? S_SUM : S_SCAN;
            end
            S_SUM: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_ACK: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CNT_START: o_cmd.div_cnt_start = 1'b1;
            S_CNT_WAIT:  o_cmd.cnt_update = i_stat.div_done;
            S_SCAN: begin
                if (!i_stat.alm_en) begin
                    o_cmd.advance = 1'b1;
                end else if (i_stat.alm_late) begin
                    o_cmd.alm_pass = 1'b1;
                    o_cmd.advance  = 1'b1;
                end else if (i_stat.alm_one) begin
                    o_cmd.alm_shot = 1'b1;
                end else begin
                    o_cmd.div_alm_start = 1'b1;
                end
            end
            S_ALM_WAIT: o_cmd.alm_div = i_stat.div_done;
            S_EMIT: begin
                o_cmd.emit_exp = i_stat.out_free;
                o_cmd.advance  = i_stat.out_free;
            end
            S_SUM: o_cmd.emit_sum = i_stat.out_free;
            S_ACK: o_cmd.emit_ack = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    ap_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.emit_exp, o_cmd.emit_sum, o_cmd.emit_ack}) <= 1)
        else $error("more than one result loaded at once");
    ap_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("item loaded while busy");
    ap_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_exp || o_cmd.emit_sum || o_cmd.emit_ack) |-> i_stat.out_free)
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire

[rtl/oace_dpath.sv]
// ----------------------------------------------------------------------------
// oace_dpath
// Counter, alarm table, shared divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oace_dpath
    import oace_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_stat,
    input  wire logic [1:0]  i_op,
    input  wire logic [55:0] i_item,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [71:0]      o_data,
    output logic [1:0]       o_kind,
    output logic             o_last
);

    logic [TIME_W-1:0] r_cmax;
    logic [TIME_W-1:0] r_counter;
    logic [TIME_W-1:0] r_rem [NUM_ALARMS];
    logic [TIME_W-1:0] r_per [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] r_en;
    logic [1:0]        r_act [NUM_ALARMS];
    logic [7:0]        r_task [NUM_ALARMS];
    logic [7:0]        r_ev [NUM_ALARMS];

    logic [1:0]        r_op;
    logic [IDX_W-1:0]  r_alarm;
    logic [TIME_W-1:0] r_amount;
    logic [TIME_W-1:0] r_cycle;
    logic [1:0]        r_action;
    logic [7:0]        r_task_req;
    logic [7:0]        r_evmask;

    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_due;
    logic [TIME_W-1:0] r_exp;

    logic              r_out_valid;
    logic [71:0]       r_out_data;
    logic [1:0]        r_out_kind;
    logic              r_out_last;

    logic              w_div_start;
    logic [DIV_W-1:0]  w_dividend;
    logic [DIV_W-1:0]  w_divisor;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quo;
    logic [DIV_W-1:0]  w_drem;
    logic [DIV_W-1:0]  w_mod;
    logic [TIME_W-1:0] w_cur_rem;
    logic [TIME_W-1:0] w_cur_per;
    logic [TIME_W-1:0] w_new_rem;
    logic [TIME_W-1:0] w_exp;
    logic              w_out_free;

    assign w_mod     = (r_cmax == '0) ? {1'b1, {TIME_W{1'b0}}} : {1'b0, r_cmax};
    assign w_cur_rem = r_rem[r_idx];
    assign w_cur_per = r_per[r_idx];
    assign w_new_rem = w_cur_per - w_drem[TIME_W-1:0];
    assign w_exp     = (w_quo[TIME_W-1:0] == {TIME_W{1'b1}}) ? {TIME_W{1'b1}}
                                                             : w_quo[TIME_W-1:0] + 1'b1;
    assign w_out_free = !r_out_valid || i_ready;

    assign w_div_start = i_cmd.div_cnt_start || i_cmd.div_alm_start;
    always_comb begin
        if (i_cmd.div_cnt_start) begin
            w_dividend = {1'b0, r_counter} + {1'b0, r_amount};
            w_divisor  = w_mod;
        end else begin
            w_dividend = {1'b0, r_amount - w_cur_rem};
            w_divisor  = {1'b0, w_cur_per};
        end
    end

    oace_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_drem)
    );

    always_comb begin
        o_stat          = '0;
        o_stat.op       = i_op;
        o_stat.out_free = w_out_free;
        o_stat.div_done = w_div_done;
        o_stat.alm_en   = r_en[r_idx];
        o_stat.alm_late = (w_cur_rem > r_amount);
        o_stat.alm_one  = (w_cur_per == '0);
        o_stat.idx_last = (r_idx == IDX_W'(NUM_ALARMS - 1));
    end

    // control state and alarm timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmax    <= {TIME_W{1'b1}};
            r_counter <= '0;
            r_en      <= '0;
            r_idx     <= '0;
            for (int i = 0; i < NUM_ALARMS; i++) begin
                r_rem[i] <= '0;
                r_per[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_cmax <= i_cfg_wdata;
            if (i_cmd.load) r_idx <= '0;
            if (i_cmd.advance) r_idx <= r_idx + 1'b1;
            if (i_cmd.cnt_update) r_counter <= w_drem[TIME_W-1:0];
            if (i_cmd.alm_pass) r_rem[r_idx] <= w_cur_rem - r_amount;
            if (i_cmd.alm_shot) begin
                r_rem[r_idx] <= '0;
                r_en[r_idx]  <= 1'b0;
            end
            if (i_cmd.alm_div) r_rem[r_idx] <= w_new_rem;
            if (i_cmd.emit_ack) begin
                if (r_op == OP_ARM) begin
                    r_rem[r_alarm] <= r_amount;
                    r_per[r_alarm] <= r_cycle;
                    r_en[r_alarm]  <= 1'b1;
                end else begin
                    r_en[r_alarm] <= 1'b0;
                end
            end
        end
    end

    // item fields, alarm actions, running minimum and expiry count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_alarm    <= i_item[2:0];
            r_amount   <= i_item[18:3];
            r_cycle    <= i_item[34:19];
            r_action   <= i_item[36:35];
            r_task_req <= i_item[44:37];
            r_evmask   <= i_item[52:45];
            r_due      <= {TIME_W{1'b1}};
        end
        if (i_cmd.alm_pass && (w_cur_rem - r_amount) < r_due) r_due <= w_cur_rem - r_amount;
        if (i_cmd.alm_shot) begin
            r_due <= '0;
            r_exp <= TIME_W'(1);
        end
        if (i_cmd.alm_div) begin
            r_exp <= w_exp;
            if (w_new_rem < r_due) r_due <= w_new_rem;
        end
        if (i_cmd.emit_ack && r_op == OP_ARM) begin
            r_act[r_alarm]  <= r_action;
            r_task[r_alarm] <= r_task_req;
            r_ev[r_alarm]   <= r_evmask;
        end
    end

    // output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_exp || i_cmd.emit_sum || i_cmd.emit_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_exp) begin
            r_out_kind <= KIND_EXPIRY;
            r_out_last <= 1'b0;
            r_out_data <= {3'b0, 16'b0, 16'b0, r_exp, r_ev[r_idx], r_task[r_idx],
                           r_act[r_idx], r_idx};
        end else if (i_cmd.emit_sum) begin
            r_out_kind <= KIND_SUMMARY;
            r_out_last <= 1'b1;
            r_out_data <= {3'b0, r_due, r_counter, 37'b0};
        end else if (i_cmd.emit_ack) begin
            r_out_kind <= KIND_ACK;
            r_out_last <= 1'b1;
            r_out_data <= {69'b0, r_alarm};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_kind  = r_out_kind;
    assign o_last  = r_out_last;

    ap_shot_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alm_shot |=> !r_en[$past(r_idx)])
        else $error("one-shot alarm still enabled after expiry");
    ap_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alm_div |-> w_drem < {1'b0, w_cur_per})
        else $error("divider remainder not below period");
    ap_cnt_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_update |=> {1'b0, r_counter} < $past(w_mod))
        else $error("counter not below modulus");

endmodule

`default_nettype wire

[rtl/os_alarm_counter_engine_top.sv]
// ----------------------------------------------------------------------------
// os_alarm_counter_engine_top
// One OS counter with a table of alarms: tick, arm and cancel.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  item in  | in  | s_tvalid/s_tready  | s_tdata, s_tuser = op
//  result   | out | m_tvalid/m_tready  | m_tdata, m_tuser = kind, m_tlast
//  config   | in  | cfg_we             | cfg_wdata = counter_max
//
// Arm and cancel are accepted in the idle state and then acknowledged. A
// tick is accepted, runs the counter modulo on the divider, then scans each
// alarm: an idle or not-due alarm is passed over in the scan state, a
// one-shot expiry goes from scan to emit, a cyclic expiry waits for the
// bit-serial divider before emit, then the summary; results wait for m_tready.
// Reset is synchronous and clears the counter, alarms and handshakes.
// One item is in work at a time; s_tready is high only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module os_alarm_counter_engine_top
    import oace_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // alarm[2:0], amount[18:3], cycle[34:19], action[36:35],
    // task_req[44:37], event_mask[52:45]
    input  wire logic [55:0] i_s_tdata,
    // op[1:0]
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // alarm_index[2:0], action_kind[4:3], target_task[12:5],
    // target_events[20:13], expiries[36:21], counter_now[52:37], next_due[68:53]
    output logic [71:0]      o_m_tdata,
    // kind[1:0]
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tlast
);

    t_cmd    w_cmd;
    t_status w_stat;

    oace_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    oace_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (i_s_tuser),
        .i_item      (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_kind      (o_m_tuser),
        .o_last      (o_m_tlast)
    );

endmodule

`default_nettype wire
